### hdl/kpc_pkg.sv
// package for the key press classifier: phase codes, register indexes and thresholds
`timescale 1ns / 1ps
`default_nettype none
package kpc_pkg;

   localparam int KEY_COUNT_DEFAULT = 4;
   localparam int LEVEL_W           = 4;
   localparam int TIME_W            = 32;
   localparam int THRESH_W          = 16;
   localparam int CSR_INDEX_W       = 1;

   localparam logic [THRESH_W-1:0] LONG_RESET  = 16'd800;
   localparam logic [THRESH_W-1:0] SHORT_RESET = 16'd50;

   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_PRESS = 1'd1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_HELD  = 2'd1,
      PH_SHORT = 2'd2,
      PH_LONG  = 2'd3
   } key_phase_type;

   typedef struct packed {
      logic [THRESH_W-1:0] long_time;
      logic [THRESH_W-1:0] short_time;
   } thresh_type;

endpackage
`default_nettype wire

### hdl/kpc_lane.sv
// one key's press classifier: phase machine and press time capture
`timescale 1ns / 1ps
`default_nettype none
module kpc_lane (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         take,
   input  wire logic                         released,
   input  wire logic [kpc_pkg::TIME_W-1:0]   now_time,
   input  wire kpc_pkg::thresh_type          thresh,
   output kpc_pkg::key_phase_type            phase_next
);

   kpc_pkg::key_phase_type          phase_ff;
   kpc_pkg::key_phase_type          phase_in;
   logic [kpc_pkg::TIME_W-1:0]      start_ff;
   logic [kpc_pkg::TIME_W-1:0]      start_in;
   logic [kpc_pkg::TIME_W-1:0]      held_time;
   logic                            reach_long;
   logic                            reach_short;

   assign held_time   = now_time - start_ff;
   assign reach_long  = held_time >= {{(kpc_pkg::TIME_W-kpc_pkg::THRESH_W){1'b0}},
                                      thresh.long_time};
   assign reach_short = held_time >= {{(kpc_pkg::TIME_W-kpc_pkg::THRESH_W){1'b0}},
                                      thresh.short_time};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (released) begin
         if (phase_ff == kpc_pkg::PH_HELD) begin
            if (reach_long) begin
               phase_in = kpc_pkg::PH_LONG;
            end else if (reach_short) begin
               phase_in = kpc_pkg::PH_SHORT;
            end else begin
               phase_in = kpc_pkg::PH_IDLE;
            end
         end else begin
            phase_in = kpc_pkg::PH_IDLE;
         end
      end else if (phase_ff == kpc_pkg::PH_IDLE) begin
         phase_in = kpc_pkg::PH_HELD;
      end
   end

   // press time capture
   always_comb begin
      start_in = start_ff;
      if (!released && phase_ff == kpc_pkg::PH_IDLE) begin
         start_in = now_time;
      end
   end

   assign phase_next = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kpc_pkg::PH_IDLE;
         start_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
   end

   a_idle_not_classified: assert property (@(posedge clock) disable iff (reset)
      phase_ff == kpc_pkg::PH_IDLE |=>
         phase_ff == kpc_pkg::PH_IDLE || phase_ff == kpc_pkg::PH_HELD)
      else $error("key left idle for a press class");

   a_class_not_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff == kpc_pkg::PH_SHORT || phase_ff == kpc_pkg::PH_LONG |=>
         phase_ff != kpc_pkg::PH_HELD)
      else $error("classified key went back to held");

   a_start_only_on_press: assert property (@(posedge clock) disable iff (reset)
      phase_ff != kpc_pkg::PH_IDLE |=> $stable(start_ff))
      else $error("press time changed outside idle");

endmodule
`default_nettype wire

### hdl/kpc_merge.sv
// result register that gathers the lane phases into the four status fields
`timescale 1ns / 1ps
`default_nettype none
module kpc_merge #(
   parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire kpc_pkg::key_phase_type  phases [KEY_COUNT],
   output logic                         in_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_key0_status,
   output logic [1:0]                   rsp_key1_status,
   output logic [1:0]                   rsp_key2_status,
   output logic [1:0]                   rsp_key3_status
);

   localparam int OUT_KEYS = 4;

   logic                valid_ff;
   logic                valid_in;
   logic [1:0]          status_ff [OUT_KEYS];
   logic [1:0]          status_in [OUT_KEYS];

   always_comb begin
      for (int k = 0; k < OUT_KEYS; k++) begin
         status_in[k] = 2'd0;
      end
      for (int k = 0; k < OUT_KEYS; k++) begin
         if (k < KEY_COUNT) begin
            status_in[k] = 2'(phases[k]);
         end
      end
   end

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_key0_status = status_ff[0];
   assign rsp_key1_status = status_ff[1];
   assign rsp_key2_status = status_ff[2];
   assign rsp_key3_status = status_ff[3];

endmodule
`default_nettype wire

### hdl/key_press_classifier_top.sv
// top level of the key press classifier: threshold registers, key lanes and result register
//
// usage
//   req channel: one scan tick per transfer, req_now_time is the tick count and
//   req_key_levels holds the raw active-low key pins (1 = released)
//   rsp channel: one transfer per scan tick with the phase of keys 0..3
//   (0 idle, 1 held, 2 short press, 3 long press)
//   csr port: csr_we writes csr_wdata into the threshold chosen by csr_index
//   (0 long press time, 1 short press time); write only while idle
// timing
//   latency is one cycle from a req transfer to rsp_valid
//   throughput is one scan tick per cycle; every key lane does its subtract and
//   two compares in the cycle of the transfer, and the result register frees
//   itself in the cycle it is taken
// reset
//   all keys go idle, press times clear, thresholds return to 800 and 50
// stall
//   while rsp_ready is low a waiting result holds and req_ready drops
`timescale 1ns / 1ps
`default_nettype none
module key_press_classifier_top #(
   parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [kpc_pkg::TIME_W-1:0]        req_now_time,
   input  wire logic [kpc_pkg::LEVEL_W-1:0]       req_key_levels,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_key0_status,
   output logic [1:0]                             rsp_key1_status,
   output logic [1:0]                             rsp_key2_status,
   output logic [1:0]                             rsp_key3_status,
   input  wire logic                              csr_we,
   input  wire logic [kpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kpc_pkg::THRESH_W-1:0]      csr_wdata
);

   kpc_pkg::thresh_type      thresh_ff;
   kpc_pkg::thresh_type      thresh_in;
   kpc_pkg::key_phase_type   phases [KEY_COUNT];
   logic                     take;

   assign take = req_valid && req_ready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_we) begin
         case (csr_index)
            kpc_pkg::CSR_LONG_PRESS:  thresh_in.long_time  = csr_wdata;
            kpc_pkg::CSR_SHORT_PRESS: thresh_in.short_time = csr_wdata;
            default:                  thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.long_time  <= kpc_pkg::LONG_RESET;
         thresh_ff.short_time <= kpc_pkg::SHORT_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
      logic released;
      // keys past the level word always see a press
      if (k < kpc_pkg::LEVEL_W) begin : g_pin
         assign released = req_key_levels[k];
      end else begin : g_nopin
         assign released = 1'b0;
      end

      kpc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .take       (take),
         .released   (released),
         .now_time   (req_now_time),
         .thresh     (thresh_ff),
         .phase_next (phases[k])
      );
   end

   kpc_merge #(
      .KEY_COUNT (KEY_COUNT)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .phases          (phases),
      .in_ready        (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key0_status (rsp_key0_status),
      .rsp_key1_status (rsp_key1_status),
      .rsp_key2_status (rsp_key2_status),
      .rsp_key3_status (rsp_key3_status)
   );

   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted scan tick gave no result");

endmodule
`default_nettype wire
